// ----- rtl/core/tbp_pkg.sv -----
// shared types and constants of the tournament branch predictor
`timescale 1ns / 1ps

package tbp_pkg;

    // default table geometry
    localparam int TBP_TABLE_ENTRIES = 2048;
    localparam int TBP_HISTORY_BITS  = 11;

    // stream payload widths, padded to whole bytes
    localparam int TBP_ADDR_W     = 48;
    localparam int TBP_S_DATA_W   = 56;
    localparam int TBP_TALLY_W    = 32;
    localparam int TBP_M_DATA_W   = 40;

    // 2-bit saturating counter
    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MAX     = 2'd3;
    localparam ctr_t CTR_MIN     = 2'd0;
    localparam ctr_t CTR_WEAK_T  = 2'd2;

    // table values after reset
    localparam ctr_t SEL_RESET = CTR_MIN;   // prefer gshare
    localparam ctr_t BIM_RESET = CTR_MAX;   // strongly taken
    localparam ctr_t GSH_RESET = CTR_MAX;   // strongly taken

    localparam logic [TBP_TALLY_W-1:0] TALLY_MAX = {TBP_TALLY_W{1'b1}};

    // control state of the top level
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } tbp_state_t;

    // outcome of one predict and update step
    typedef struct packed {
        logic pred;
        logic use_bim;
        logic right;
        ctr_t sel_next;
        ctr_t bim_next;
        ctr_t gsh_next;
    } upd_t;

endpackage

// ----- rtl/core/tournament_branch_predictor_unit.sv -----
// top level of the tournament (gshare + bimodal) branch predictor
`timescale 1ns / 1ps

// Usage
// Input stream: one resolved conditional branch per item, tdata carries the
// 48-bit branch address in bits 47:0 and the outcome (1 taken) in bit 48.
// Output stream: one result per input item, tdata carries the chosen
// prediction in bit 0, the bimodal-chosen flag in bit 1, the correct flag in
// bit 2 and the saturating count of correct predictions in bits 34:3.
// Throughput: one item per cycle, sustained, while m_axis_tready is high. The
// three counter tables are synchronous memories read on the accepting edge and
// written back as the item leaves the update stage; a last-write register per
// table forwards that write to the next item so back-to-back branches to the
// same entry see updated values.
// Path: tables read on the accepting edge, update worked out in the update
// stage, result loaded into the output register as the item leaves that stage.
// Reset: after rst_n is released the block sweeps every table entry to its
// initial value, one entry per cycle; s_axis_tready stays low during that sweep.
// History and count start at zero.
// Stall: when m_axis_tready is low the result stays in the output register,
// one more item can sit in the update stage, and then s_axis_tready drops.
// TABLE_ENTRIES must be a power of two; the address modulo is its low bits.

module tournament_branch_predictor_unit #(
    parameter int TABLE_ENTRIES = tbp_pkg::TBP_TABLE_ENTRIES,
    parameter int HISTORY_BITS  = tbp_pkg::TBP_HISTORY_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [47:0] branch_address, [48] taken, [55:49] zero
    input  logic [tbp_pkg::TBP_S_DATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] predicted_taken, [1] used_bimodal, [2] prediction_correct,
    // [34:3] correct_total, [39:35] zero
    output logic [tbp_pkg::TBP_M_DATA_W-1:0]  m_axis_tdata
);
    import tbp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int XOR_W = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;
    localparam int PAD_W = TBP_M_DATA_W - TBP_TALLY_W - 3;

    tbp_state_t state_reg;
    tbp_state_t state_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic clearing;

    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;

    logic             in_taken;
    logic [IDX_W-1:0] in_bidx;
    logic [IDX_W-1:0] in_gidx;
    logic [XOR_W-1:0] gidx_wide;
    logic             s_accept;

    // update stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [IDX_W-1:0] s1_bidx_reg;
    logic [IDX_W-1:0] s1_gidx_reg;
    logic             s1_taken_reg;
    logic             s1_adv;

    // last write, forwarded to the next item
    logic             lw_valid_reg;
    logic [IDX_W-1:0] lw_bidx_reg;
    logic [IDX_W-1:0] lw_gidx_reg;
    ctr_t             lw_sel_reg;
    ctr_t             lw_bim_reg;
    ctr_t             lw_gsh_reg;

    ctr_t sel_rd;
    ctr_t bim_rd;
    ctr_t gsh_rd;
    ctr_t sel_cur;
    ctr_t bim_cur;
    ctr_t gsh_cur;
    upd_t upd;

    logic             mem_we;
    logic [IDX_W-1:0] b_wa;
    logic [IDX_W-1:0] g_wa;
    ctr_t             sel_wd;
    ctr_t             bim_wd;
    ctr_t             gsh_wd;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_pred_reg;
    logic                   out_use_bim_reg;
    logic                   out_right_reg;
    logic [TBP_TALLY_W-1:0] tally_reg;
    logic [TBP_TALLY_W-1:0] tally_next;

    // clearing sweep after reset
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // input side: index forming and handshake
    assign in_taken  = s_axis_tdata[TBP_ADDR_W];
    assign in_bidx   = s_axis_tdata[IDX_W-1:0];
    assign gidx_wide = XOR_W'(in_bidx) ^ XOR_W'(hist_reg);
    assign in_gidx   = gidx_wide[IDX_W-1:0];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clearing && (!s1_valid_reg || s1_adv);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign hist_next     = s_accept ? {hist_reg[HISTORY_BITS-2:0], in_taken} : hist_reg;
    assign s1_valid_next = s_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // memory write port: sweep values or written-back counters
    assign mem_we = clearing || s1_adv;
    assign b_wa   = clearing ? clr_idx_reg : s1_bidx_reg;
    assign g_wa   = clearing ? clr_idx_reg : s1_gidx_reg;
    assign sel_wd = clearing ? SEL_RESET : upd.sel_next;
    assign bim_wd = clearing ? BIM_RESET : upd.bim_next;
    assign gsh_wd = clearing ? GSH_RESET : upd.gsh_next;

    tbp_counter_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_sel_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (b_wa),
        .wr_data (sel_wd),
        .rd_en   (s_accept),
        .rd_addr (in_bidx),
        .rd_data (sel_rd)
    );

    tbp_counter_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_bim_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (b_wa),
        .wr_data (bim_wd),
        .rd_en   (s_accept),
        .rd_addr (in_bidx),
        .rd_data (bim_rd)
    );

    tbp_counter_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_gsh_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (g_wa),
        .wr_data (gsh_wd),
        .rd_en   (s_accept),
        .rd_addr (in_gidx),
        .rd_data (gsh_rd)
    );

    // forwarding from the write made on the accepting edge
    always_comb
    begin
        sel_cur = sel_rd;
        bim_cur = bim_rd;
        gsh_cur = gsh_rd;
        if (lw_valid_reg && (lw_bidx_reg == s1_bidx_reg))
        begin
            sel_cur = lw_sel_reg;
            bim_cur = lw_bim_reg;
        end
        if (lw_valid_reg && (lw_gidx_reg == s1_gidx_reg))
        begin
            gsh_cur = lw_gsh_reg;
        end
    end

    tbp_update u_update (
        .sel   (sel_cur),
        .bim   (bim_cur),
        .gsh   (gsh_cur),
        .taken (s1_taken_reg),
        .upd   (upd)
    );

    // saturating count of correct predictions
    assign tally_next = (upd.right && (tally_reg != TALLY_MAX)) ?
                        tally_reg + 1'b1 : tally_reg;

    assign out_valid_next = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            hist_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hist_reg      <= hist_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                lw_valid_reg <= 1'b1;
                tally_reg    <= tally_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_bidx_reg  <= in_bidx;
            s1_gidx_reg  <= in_gidx;
            s1_taken_reg <= in_taken;
        end
        if (s1_adv)
        begin
            lw_bidx_reg     <= s1_bidx_reg;
            lw_gidx_reg     <= s1_gidx_reg;
            lw_sel_reg      <= upd.sel_next;
            lw_bim_reg      <= upd.bim_next;
            lw_gsh_reg      <= upd.gsh_next;
            out_pred_reg    <= upd.pred;
            out_use_bim_reg <= upd.use_bim;
            out_right_reg   <= upd.right;
        end
    end

    // output stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, tally_reg, out_right_reg,
                            out_use_bim_reg, out_pred_reg};

endmodule

// ----- rtl/core/tbp_counter_ram.sv -----
// single-port-write, single-port-read counter memory with registered read
`timescale 1ns / 1ps

module tbp_counter_ram #(
    parameter int DEPTH = tbp_pkg::TBP_TABLE_ENTRIES,
    parameter int AW    = $clog2(tbp_pkg::TBP_TABLE_ENTRIES)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tbp_pkg::ctr_t wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output tbp_pkg::ctr_t rd_data
);
    import tbp_pkg::*;

    ctr_t mem [DEPTH];
    ctr_t rd_data_reg;

    // write and read-old-data in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tbp_update.sv -----
// prediction choice and counter updates for one resolved branch
`timescale 1ns / 1ps

module tbp_update (
    input  tbp_pkg::ctr_t sel,
    input  tbp_pkg::ctr_t bim,
    input  tbp_pkg::ctr_t gsh,
    input  logic          taken,
    output tbp_pkg::upd_t upd
);
    import tbp_pkg::*;

    logic bim_pred;
    logic gsh_pred;
    logic bim_right;
    logic gsh_right;
    logic use_bim;
    logic pred;

    function automatic ctr_t sat_step(input ctr_t c, input logic up);
        ctr_t r;
        r = c;
        if (up)
        begin
            if (c != CTR_MAX)
            begin
                r = c + 2'd1;
            end
        end
        else
        begin
            if (c != CTR_MIN)
            begin
                r = c - 2'd1;
            end
        end
        return r;
    endfunction

    // component predictions and the selector's choice
    always_comb
    begin
        bim_pred  = (bim >= CTR_WEAK_T);
        gsh_pred  = (gsh >= CTR_WEAK_T);
        bim_right = (bim_pred == taken);
        gsh_right = (gsh_pred == taken);
        use_bim   = (sel >= CTR_WEAK_T);
        pred      = use_bim ? bim_pred : gsh_pred;
    end

    // new counter values; selector moves toward the component that alone was right
    always_comb
    begin
        upd.pred     = pred;
        upd.use_bim  = use_bim;
        upd.right    = (pred == taken);
        upd.bim_next = sat_step(bim, taken);
        upd.gsh_next = sat_step(gsh, taken);
        priority if (bim_right && !gsh_right)
        begin
            upd.sel_next = sat_step(sel, 1'b1);
        end
        else if (gsh_right && !bim_right)
        begin
            upd.sel_next = sat_step(sel, 1'b0);
        end
        else
        begin
            upd.sel_next = sel;
        end
    end

endmodule

// ----- rtl/core/tbp_checker.sv -----
// port-level checks of the branch predictor, bound to the top level
`timescale 1ns / 1ps

module tbp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [tbp_pkg::TBP_S_DATA_W-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tbp_pkg::TBP_M_DATA_W-1:0]  m_axis_tdata
);
    import tbp_pkg::*;

    logic m_hs;
    logic [TBP_TALLY_W-1:0] total;

    assign m_hs  = m_axis_tvalid && m_axis_tready;
    assign total = m_axis_tdata[TBP_TALLY_W+2:3];

    // an offered input item waits unchanged until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input item changed while waiting");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // when reset is released: no input taken, no result shown
    a_reset_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block active during table sweep");

    // a correct prediction advances the count by one, unless saturated
    a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_hs ##1 (m_hs && m_axis_tdata[2]) |->
            (total == $past(total) + 32'd1) || ($past(total) == TALLY_MAX))
        else $error("count did not advance on a correct prediction");

    // a wrong prediction leaves the count unchanged
    a_tally_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_hs ##1 (m_hs && !m_axis_tdata[2]) |-> total == $past(total))
        else $error("count changed on a wrong prediction");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_top.sv -----
// self-checking stream testbench for the tournament branch predictor
`timescale 1ns / 1ps

module tb_top;

    import tbp_pkg::*;

    localparam int IDX_W        = $clog2(TBP_TABLE_ENTRIES);
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOT_COUNT    = 24;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 4 * TBP_TABLE_ENTRIES;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [TBP_ADDR_W-1:0] addr;
        logic                  taken;
    } branch_t;

    typedef struct {
        logic                   pred;
        logic                   use_bim;
        logic                   right;
        logic [TBP_TALLY_W-1:0] total;
    } outcome_t;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TBP_S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TBP_M_DATA_W-1:0] m_axis_tdata;

    branch_t  pending_branches[$];
    outcome_t expected_outcomes[$];

    // predictor state
    ctr_t                        sel_ctr [TBP_TABLE_ENTRIES];
    ctr_t                        bim_ctr [TBP_TABLE_ENTRIES];
    ctr_t                        gsh_ctr [TBP_TABLE_ENTRIES];
    logic [TBP_HISTORY_BITS-1:0] ghist;
    logic [TBP_TALLY_W-1:0]      correct_count;

    int items_in     = 0;
    int total_items  = 0;
    int errors       = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int src_gap_pct;
    int sink_stall_pct;

    // hot branch pool for loop-like traffic
    logic [TBP_ADDR_W-1:0] hot_addr [HOT_COUNT];
    int                    hot_period [HOT_COUNT];
    logic [7:0]            hot_pattern [HOT_COUNT];
    int                    hot_iter [HOT_COUNT];

    tournament_branch_predictor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idling by phase: receiver-heavy, then sender-heavy, then none
    assign src_gap_pct    = (items_in < total_items / 3)     ? 38 :
                            (items_in < 2 * total_items / 3) ? 48 : 0;
    assign sink_stall_pct = (items_in < total_items / 3)     ? 48 :
                            (items_in < 2 * total_items / 3) ? 38 : 0;

    function automatic ctr_t sat_step(input ctr_t c, input logic up);
        if (up)
            return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
        return (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
    endfunction

    // work out the result of one branch and train the tables
    task automatic predict_branch(input logic [TBP_ADDR_W-1:0] addr, input logic taken);
        logic [IDX_W-1:0] bidx;
        logic [IDX_W-1:0] gidx;
        ctr_t             sel;
        ctr_t             bc;
        ctr_t             gc;
        logic             bpred;
        logic             gpred;
        logic             bright;
        logic             gright;
        outcome_t         o;
        bidx   = addr[IDX_W-1:0];
        gidx   = IDX_W'(32'(bidx) ^ 32'(ghist));
        sel    = sel_ctr[bidx];
        bc     = bim_ctr[bidx];
        gc     = gsh_ctr[gidx];
        bpred  = (bc >= CTR_WEAK_T);
        gpred  = (gc >= CTR_WEAK_T);
        bright = (bpred == taken);
        gright = (gpred == taken);
        o.use_bim = (sel >= CTR_WEAK_T);
        o.pred    = o.use_bim ? bpred : gpred;
        o.right   = (o.pred == taken);
        if (o.right && correct_count != TALLY_MAX)
            correct_count = correct_count + 1'b1;
        o.total = correct_count;
        bim_ctr[bidx] = sat_step(bc, taken);
        gsh_ctr[gidx] = sat_step(gc, taken);
        if (bright && !gright)
            sel_ctr[bidx] = sat_step(sel, 1'b1);
        else if (gright && !bright)
            sel_ctr[bidx] = sat_step(sel, 1'b0);
        ghist = {ghist[TBP_HISTORY_BITS-2:0], taken};
        expected_outcomes.push_back(o);
    endtask

    task automatic queue_branch(input logic [TBP_ADDR_W-1:0] addr, input logic taken);
        branch_t b;
        b.addr  = addr;
        b.taken = taken;
        pending_branches.push_back(b);
    endtask

    function automatic logic [TBP_ADDR_W-1:0] rand_addr();
        return TBP_ADDR_W'({$urandom, $urandom});
    endfunction

    // stimulus, reset and end of run
    initial
    begin
        int   k;
        int   r;
        logic t;
        for (int i = 0; i < TBP_TABLE_ENTRIES; i++)
        begin
            sel_ctr[i] = SEL_RESET;
            bim_ctr[i] = BIM_RESET;
            gsh_ctr[i] = GSH_RESET;
        end
        ghist         = '0;
        correct_count = '0;

        // directed: saturation at both ends, same entry back to back
        repeat (4) queue_branch(48'h0, 1'b0);
        repeat (2) queue_branch(48'hFFFF_FFFF_FFFF, 1'b1);
        // aliasing on entry zero from high address bits
        queue_branch(48'hFFFF_FFFF_F800, 1'b0);
        queue_branch(48'h8000_0000_0000, 1'b1);
        // top table entry
        queue_branch(48'h0000_0000_07FF, 1'b0);
        // short loop so that the selector moves both ways
        for (int i = 0; i < 12; i++)
            queue_branch(48'h0000_1234_5040, (i % 3) != 2);
        queue_branch(48'h5555_5555_5555, 1'b1);
        queue_branch(48'hAAAA_AAAA_AAAA, 1'b0);

        // hot pool, the last few alias the first few in the low bits
        for (int i = 0; i < HOT_COUNT; i++)
        begin
            hot_addr[i]    = rand_addr();
            if (i >= HOT_COUNT - 4)
                hot_addr[i][IDX_W-1:0] = hot_addr[i - (HOT_COUNT - 4)][IDX_W-1:0];
            hot_period[i]  = $urandom_range(8, 1);
            hot_pattern[i] = 8'($urandom);
            hot_iter[i]    = 0;
        end

        // random: mostly loop patterns, some biased, some pure noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(99);
            k = $urandom_range(HOT_COUNT - 1);
            if (r < 70)
            begin
                t = hot_pattern[k][hot_iter[k] % hot_period[k]];
                hot_iter[k]++;
                queue_branch(hot_addr[k], t);
            end
            else if (r < 85)
                queue_branch(hot_addr[k], $urandom_range(99) < 90);
            else
                queue_branch(rand_addr(), 1'($urandom));
        end
        total_items = pending_branches.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!(items_in == total_items && expected_outcomes.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // driver: offer pending items, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        branch_t b;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_branch(s_axis_tdata[TBP_ADDR_W-1:0], s_axis_tdata[TBP_ADDR_W]);
                items_in <= items_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_branches.size() != 0 && $urandom_range(99) >= src_gap_pct)
                begin
                    b = pending_branches.pop_front();
                    s_axis_tdata  <= TBP_S_DATA_W'({b.taken, b.addr});
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off late in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!hold_done && total_items != 0 && items_in >= total_items * 5 / 6)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                // tdata: [0] pred, [1] bimodal chosen, [2] correct, [34:3] count
                if (m_axis_tdata[0] !== want.pred)
                begin
                    $error("predicted_taken: expected %0d, got %0d", want.pred, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== want.use_bim)
                begin
                    $error("used_bimodal: expected %0d, got %0d", want.use_bim, m_axis_tdata[1]);
                    errors++;
                end
                if (m_axis_tdata[2] !== want.right)
                begin
                    $error("prediction_correct: expected %0d, got %0d",
                           want.right, m_axis_tdata[2]);
                    errors++;
                end
                if (m_axis_tdata[3 +: TBP_TALLY_W] !== want.total)
                begin
                    $error("correct_total: expected %0d, got %0d",
                           want.total, m_axis_tdata[3 +: TBP_TALLY_W]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
